[src/cdt_pkg.sv]
// Shared types and constants for the connection demux table.
package cdt_pkg;

   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      MATCH_MISS   = 2'd0,
      MATCH_EXACT  = 2'd1,
      MATCH_LISTEN = 2'd2
   } match_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOOKUP,
      ST_DRAIN,
      ST_INSERT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0] local_addr;
      logic [15:0] local_port;
      logic [31:0] remote_addr;
      logic [15:0] remote_port;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic lk_step;
      logic ins_step;
      logic ins_write;
      logic rm_clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      req_kind_type op;
      logic         idx_last;
      logic         slot_free;
      logic         out_free;
   } stat_type;

endpackage

[src/cdt_ctrl.sv]
// Request sequencer for the connection demux table.
module cdt_ctrl
   import cdt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               REQ_LOOKUP: state_in = ST_LOOKUP;
               REQ_INSERT: state_in = ST_INSERT;
               REQ_REMOVE: begin
                  cmd.rm_clear = 1'b1;
                  state_in     = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_LOOKUP: begin
            cmd.lk_step = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The compare for the last slot lands in this cycle.
            state_in = ST_DONE;
         end
         ST_INSERT: begin
            if (stat.slot_free) begin
               cmd.ins_write = 1'b1;
               state_in      = ST_DONE;
            end else if (stat.idx_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.ins_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[src/cdt_datapath.sv]
// Entry memory, valid bits, scan compare and result register of the demux table.
module cdt_datapath
   import cdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,
   input  cmd_type                cmd,
   output stat_type               stat
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   entry_type mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   // Captured request.
   req_kind_type op_ff;
   entry_type    tuple_ff;
   logic [5:0]   slot_in_ff;

   logic [IDX_W-1:0] idx_ff;

   // Read stage of the scan.
   entry_type        rd_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             cmp_en_ff;

   logic             exact_hit_ff, listen_hit_ff, ins_ok_ff;
   logic [IDX_W-1:0] exact_slot_ff, listen_slot_ff;

   logic                   rsp_vld_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   logic             local_eq, remote_eq, remote_zero;
   logic [IDX_W+5:0] sidx_wide;
   logic             sidx_ok;
   match_kind_type   res_kind;
   logic [IDX_W-1:0] res_slot;
   logic             res_status;
   logic [IDX_W+5:0] slot_wide;

   assign sidx_wide = (IDX_W + 6)'(slot_in_ff);
   assign sidx_ok   = sidx_wide < (IDX_W + 6)'(TABLE_DEPTH);

   assign local_eq    = (rd_ff.local_addr == tuple_ff.local_addr) &&
                        (rd_ff.local_port == tuple_ff.local_port);
   assign remote_eq   = (rd_ff.remote_addr == tuple_ff.remote_addr) &&
                        (rd_ff.remote_port == tuple_ff.remote_port);
   assign remote_zero = (rd_ff.remote_addr == 32'd0) && (rd_ff.remote_port == 16'd0);

   always_ff @(posedge clock) begin
      if (cmd.ins_write) begin
         mem[idx_ff] <= tuple_ff;
      end
      rd_ff     <= mem[idx_ff];
      rd_vld_ff <= valid_ff[idx_ff];
      rd_idx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff                <= req_kind_type'(req_tuser);
         tuple_ff.local_addr  <= req_tdata[31:0];
         tuple_ff.local_port  <= req_tdata[47:32];
         tuple_ff.remote_addr <= req_tdata[79:48];
         tuple_ff.remote_port <= req_tdata[95:80];
         slot_in_ff           <= req_tdata[101:96];
      end
      if (cmd.finish) begin
         rsp_data_ff <= {1'b0, res_status, slot_wide[5:0]};
         rsp_user_ff <= res_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         idx_ff         <= '0;
         cmp_en_ff      <= 1'b0;
         exact_hit_ff   <= 1'b0;
         listen_hit_ff  <= 1'b0;
         ins_ok_ff      <= 1'b0;
         exact_slot_ff  <= '0;
         listen_slot_ff <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.lk_step;
         if (cmd.capture) begin
            idx_ff        <= '0;
            exact_hit_ff  <= 1'b0;
            listen_hit_ff <= 1'b0;
            ins_ok_ff     <= 1'b0;
         end else if (cmd.lk_step || cmd.ins_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // Lowest exact match wins; the lowest listener is kept as fallback.
         if (cmp_en_ff && rd_vld_ff && local_eq) begin
            if (remote_eq) begin
               if (!exact_hit_ff) begin
                  exact_hit_ff  <= 1'b1;
                  exact_slot_ff <= rd_idx_ff;
               end
            end else if (remote_zero && !listen_hit_ff) begin
               listen_hit_ff  <= 1'b1;
               listen_slot_ff <= rd_idx_ff;
            end
         end
         if (cmd.ins_write) begin
            valid_ff[idx_ff] <= 1'b1;
            ins_ok_ff        <= 1'b1;
         end
         if (cmd.rm_clear && sidx_ok) begin
            valid_ff[sidx_wide[IDX_W-1:0]] <= 1'b0;
         end
         if (cmd.finish) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      res_kind   = MATCH_MISS;
      res_slot   = '0;
      res_status = 1'b0;
      case (op_ff)
         REQ_LOOKUP: begin
            if (exact_hit_ff) begin
               res_kind = MATCH_EXACT;
               res_slot = exact_slot_ff;
            end else if (listen_hit_ff) begin
               res_kind = MATCH_LISTEN;
               res_slot = listen_slot_ff;
            end
         end
         REQ_INSERT: begin
            if (ins_ok_ff) begin
               res_slot = idx_ff;
            end else begin
               res_status = 1'b1;
            end
         end
         default: res_kind = MATCH_MISS;
      endcase
   end

   assign slot_wide = (IDX_W + 6)'(res_slot);

   assign stat.op        = op_ff;
   assign stat.idx_last  = idx_ff == IDX_W'(TABLE_DEPTH - 1);
   assign stat.slot_free = !valid_ff[idx_ff];
   assign stat.out_free  = !rsp_vld_ff || rsp_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[src/connection_demux_table.sv]
// Top level of the connection demux table: TCP 4-tuple table with exact then listen lookup.
//
// Channel   Direction  tuser           tdata
// req_      in         request kind    local addr/port, remote addr/port, slot to remove
// rsp_      out        match kind      slot, full status
//
// Every request is carried out one at a time by a sequencer over a single-port entry memory.
// A lookup reads one slot per cycle and scans every slot before it gives a result.
// An insert walks the valid bits from slot 0 and writes the first free slot, or reports a
// full table when none is free. A remove or an unknown request does not scan the table.
// Reset clears the valid bits at once, so no clearing pass is needed; entry contents are
// left as they are. A finished result waits in the output register, and the next request
// transfer is taken while it waits; the result after that waits until the register drains.
module connection_demux_table
   import cdt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] local_addr, [47:32] local_port, [79:48] remote_addr, [95:80] remote_port,
   // [101:96] slot_in, [103:102] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [5:0] slot_out, [6] status, [7] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] match_kind
   output logic [1:0]             rsp_tuser
);

   cmd_type  ctrl_cmd;
   stat_type dp_stat;

   // The sequencer decides what happens in each cycle of a request.
   cdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   // The datapath holds the table, the scan compare and the result register.
   cdt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat)
   );

`ifndef SYNTHESIS
   // A request transfer is never followed at once by another one.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken in two consecutive cycles");

   // A table write and a slot clear never happen in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ctrl_cmd.ins_write && ctrl_cmd.rm_clear))
      else $error("insert and remove issued together");

   // A result never reports both a match and a full table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != MATCH_MISS) |-> !rsp_tdata[6])
      else $error("match result flagged as full");
`endif

endmodule
